// ===== hdl/mfd_pkg.sv =====
// Shared types, constants and helper functions of the motor feedback decoder.
`default_nettype none

package mfd_pkg;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    CFG_ANGLE_SCALE     = 3'd0,
    CFG_SPEED_SCALE     = 3'd1,
    CFG_CURRENT_SCALE   = 3'd2,
    CFG_POWER_K_CROSS   = 3'd3,
    CFG_POWER_K_SPEED   = 3'd4,
    CFG_POWER_K_CURRENT = 3'd5,
    CFG_POWER_OFFSET    = 3'd6
  } cfg_idx_e;

  localparam logic [31:0] ANGLE_SCALE_RST   = 32'd3294199;
  localparam logic [31:0] SPEED_SCALE_RST   = 32'd1756906;
  localparam logic [31:0] CURRENT_SCALE_RST = 32'd16777;

  typedef struct packed {
    logic [31:0] angle_scale;
    logic [31:0] speed_scale;
    logic [31:0] current_scale;
    logic [31:0] k_cross;
    logic [31:0] k_speed;
    logic [31:0] k_current;
    logic [31:0] offset;
  } cfg_t;

  // Input item
  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [12:0]        rotor_position;
    logic signed [15:0] speed_rpm;
    logic signed [15:0] current_raw;
    logic [7:0]         temperature_c;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [47:0] turn_count_total;
    logic signed [47:0] angle_rad;
    logic signed [31:0] speed_rad_s;
    logic signed [31:0] current_amp;
    logic [15:0]        temperature_ck;
    logic signed [47:0] power_est;
    logic               motor_online;
  } result_t;

  // Saturation width of a scaled product
  typedef enum logic [1:0] {
    SAT32 = 2'd0,
    SAT48 = 2'd1,
    SAT63 = 2'd2
  } sat_e;

  // One request to the shared multiply, round and saturate unit
  typedef struct packed {
    logic        start;
    logic [47:0] a_mag;
    logic [31:0] b_mag;
    logic        neg;
    logic        sh16;
    sat_e        sat;
  } mul_req_t;

  function automatic logic [15:0] mag16(input logic [15:0] x);
    return x[15] ? (16'd0 - x) : x;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  function automatic logic [47:0] mag48(input logic [47:0] x);
    return x[47] ? (48'd0 - x) : x;
  endfunction

  // Clamp a two's complement 64-bit value to 48 bits.
  function automatic logic [47:0] sat48(input logic [63:0] v);
    logic [47:0] r;
    if (!v[63] && (v[62:47] != 16'h0000)) begin
      r = 48'h7FFF_FFFF_FFFF;
    end else if (v[63] && (v[62:47] != 16'hFFFF)) begin
      r = 48'h8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mfd_if.sv =====
// Valid/ready channel interfaces for feedback items and decoded results.
`default_nettype none

interface mfd_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [12:0]        rotor_position;
  logic signed [15:0] speed_rpm;
  logic signed [15:0] current_raw;
  logic [7:0]         temperature_c;

  modport source (
    output valid, command, rotor_position, speed_rpm, current_raw, temperature_c,
    input  ready
  );
  modport sink (
    input  valid, command, rotor_position, speed_rpm, current_raw, temperature_c,
    output ready
  );
endinterface

interface mfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] turn_count_total;
  logic signed [47:0] angle_rad;
  logic signed [31:0] speed_rad_s;
  logic signed [31:0] current_amp;
  logic [15:0]        temperature_ck;
  logic signed [47:0] power_est;
  logic               motor_online;

  modport source (
    output valid, turn_count_total, angle_rad, speed_rad_s, current_amp,
           temperature_ck, power_est, motor_online,
    input  ready
  );
  modport sink (
    input  valid, turn_count_total, angle_rad, speed_rad_s, current_amp,
           temperature_ck, power_est, motor_online,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/mfd_cfg_regs.sv =====
// APB-style register file holding the scale factors and power coefficients.
`default_nettype none

module mfd_cfg_regs
  import mfd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q;
  cfg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_scale   <= ANGLE_SCALE_RST;
      cfg_q.speed_scale   <= SPEED_SCALE_RST;
      cfg_q.current_scale <= CURRENT_SCALE_RST;
      cfg_q.k_cross       <= '0;
      cfg_q.k_speed       <= '0;
      cfg_q.k_current     <= '0;
      cfg_q.offset        <= '0;
    end else if (wr_en) begin
      unique case (idx)
        CFG_ANGLE_SCALE:     cfg_q.angle_scale   <= pwdata;
        CFG_SPEED_SCALE:     cfg_q.speed_scale   <= pwdata;
        CFG_CURRENT_SCALE:   cfg_q.current_scale <= pwdata;
        CFG_POWER_K_CROSS:   cfg_q.k_cross       <= pwdata;
        CFG_POWER_K_SPEED:   cfg_q.k_speed       <= pwdata;
        CFG_POWER_K_CURRENT: cfg_q.k_current     <= pwdata;
        CFG_POWER_OFFSET:    cfg_q.offset        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      CFG_ANGLE_SCALE:     prdata = cfg_q.angle_scale;
      CFG_SPEED_SCALE:     prdata = cfg_q.speed_scale;
      CFG_CURRENT_SCALE:   prdata = cfg_q.current_scale;
      CFG_POWER_K_CROSS:   prdata = cfg_q.k_cross;
      CFG_POWER_K_SPEED:   prdata = cfg_q.k_speed;
      CFG_POWER_K_CURRENT: prdata = cfg_q.k_current;
      CFG_POWER_OFFSET:    prdata = cfg_q.offset;
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/mfd_mul_unit.sv =====
// Shared multiply, round-to-nearest and saturate unit for sign-magnitude operands.
`default_nettype none

module mfd_mul_unit
  import mfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mul_req_t           req_i,
  output logic                    done_o,
  output logic signed [63:0]      res_o
);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_HI   = 4'b0010,
    U_ADD  = 4'b0100,
    U_RND  = 4'b1000
  } ust_e;

  ust_e        state_q;
  logic        done_q;
  logic [63:0] prod_q;
  logic [79:0] acc_q;
  logic [15:0] a_hi_q;
  logic [31:0] b_q;
  logic        neg_q;
  logic        sh16_q;
  sat_e        sat_q;
  logic [62:0] mag_q;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod_d;
  logic [72:0] rnd_x;
  logic [73:0] rnd_sum;
  logic [72:0] rnd_mag;
  logic [63:0] cap64;
  logic [72:0] cap;
  logic [62:0] mag_d;
  logic [63:0] mag64;

  // The low 32 bits of the first operand go through first, its upper bits second.
  assign mul_a  = (state_q == U_IDLE) ? req_i.a_mag[31:0] : {16'b0, a_hi_q};
  assign mul_b  = (state_q == U_IDLE) ? req_i.b_mag : b_q;
  assign prod_d = 64'(mul_a) * 64'(mul_b);

  // Rounding half away from zero on the magnitude: add one below the cut, then drop it.
  assign rnd_x   = sh16_q ? {8'b0, acc_q[79:15]} : acc_q[79:7];
  assign rnd_sum = {1'b0, rnd_x} + 74'd1;
  assign rnd_mag = rnd_sum[73:1];

  always_comb begin
    unique case (sat_q)
      SAT32:   cap64 = (64'd1 << 31) - {63'b0, !neg_q};
      SAT48:   cap64 = (64'd1 << 47) - {63'b0, !neg_q};
      SAT63:   cap64 = (64'd1 << 62) - {63'b0, !neg_q};
      default: cap64 = (64'd1 << 62) - {63'b0, !neg_q};
    endcase
  end

  assign cap   = {9'b0, cap64};
  assign mag_d = (rnd_mag > cap) ? cap[62:0] : rnd_mag[62:0];

  assign mag64  = {1'b0, mag_q};
  assign res_o  = neg_q ? $signed(64'd0 - mag64) : $signed(mag64);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == U_RND);
      unique case (state_q)
        U_IDLE:  if (req_i.start) begin
          state_q <= U_HI;
        end
        U_HI:    state_q <= U_ADD;
        U_ADD:   state_q <= U_RND;
        U_RND:   state_q <= U_IDLE;
        default: state_q <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: if (req_i.start) begin
        prod_q <= prod_d;
        a_hi_q <= req_i.a_mag[47:32];
        b_q    <= req_i.b_mag;
        neg_q  <= req_i.neg;
        sh16_q <= req_i.sh16;
        sat_q  <= req_i.sat;
      end
      U_HI: begin
        prod_q <= prod_d;
        acc_q  <= {16'b0, prod_q};
      end
      U_ADD:   acc_q <= acc_q + {prod_q[47:0], 32'b0};
      U_RND:   mag_q <= mag_d;
      default: ;
    endcase
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == U_IDLE))
    else $error("multiply unit started while busy");

  a_done_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == U_RND))
    else $error("multiply unit finished without a rounding cycle");

  a_sat32_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !neg_q && (sat_q == SAT32)) |-> (mag_q[62:31] == '0))
    else $error("32-bit result escaped its saturation bound");

endmodule

`default_nettype wire

// ===== hdl/mfd_seq.sv =====
// Sequencer: turn unwrapping, heartbeat tracking and the order of scaled products.
`default_nettype none

module mfd_seq
  import mfd_pkg::*;
#(
  parameter int unsigned COUNTS_PER_TURN = 8192,
  parameter int unsigned TURN_BITS       = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire in_item_t      item_i,
  output mul_req_t           mul_req_o,
  input  wire logic          mul_done_i,
  input  wire logic [63:0]   mul_res_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output result_t            res_o
);

  localparam logic signed [17:0] HALF_TURN = 18'(COUNTS_PER_TURN / 2);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UNWRAP = 7'b0000010,
    S_TOTAL  = 7'b0000100,
    S_ISSUE  = 7'b0001000,
    S_WAIT   = 7'b0010000,
    S_SAT    = 7'b0100000,
    S_DONE   = 7'b1000000
  } sst_e;

  // Products in issue order; each power term follows the product it scales.
  typedef enum logic [3:0] {
    OP_ANG = 4'd0,
    OP_SPD = 4'd1,
    OP_CUR = 4'd2,
    OP_CS  = 4'd3,
    OP_KC  = 4'd4,
    OP_SS  = 4'd5,
    OP_KS  = 4'd6,
    OP_CC  = 4'd7,
    OP_KI  = 4'd8
  } op_e;

  sst_e                  state_q;
  op_e                   op_q;
  logic [12:0]           last_pos_q;
  logic [TURN_BITS-1:0]  turn_q;
  logic [TURN_BITS-1:0]  turn_d;
  logic                  frame_seen_q;
  logic                  online_q;
  logic [47:0]           total_q;
  logic [47:0]           ang_q;
  logic [31:0]           spd_q;
  logic [31:0]           cur_q;
  logic [15:0]           tck_q;
  logic [47:0]           pw_q;

  logic [12:0]           pos_q;
  logic [15:0]           rpm_q;
  logic [15:0]           raw_q;
  logic [7:0]            temp_q;
  logic [47:0]           term_q;
  logic [63:0]           pwacc_q;

  logic signed [13:0]          delta;
  logic signed [17:0]          delta_ext;
  logic signed [TURN_BITS+17:0] tprod;
  logic [63:0]                 tot_full;
  logic [15:0]                 tck_d;
  logic                        accept;
  mul_req_t                    req;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  // Half-turn test on the step between consecutive positions.
  assign delta     = $signed({1'b0, pos_q}) - $signed({1'b0, last_pos_q});
  assign delta_ext = {{4{delta[13]}}, delta};

  always_comb begin
    if (delta_ext < -HALF_TURN) begin
      turn_d = turn_q + TURN_BITS'(1);
    end else if (delta_ext > HALF_TURN) begin
      turn_d = turn_q - TURN_BITS'(1);
    end else begin
      turn_d = turn_q;
    end
  end

  assign tprod    = $signed(turn_q) * $signed(18'(COUNTS_PER_TURN));
  assign tot_full = {{(46-TURN_BITS){tprod[TURN_BITS+17]}}, tprod} + {51'b0, pos_q};
  assign tck_d    = ({8'b0, temp_q} * 16'd100) + 16'd27315;

  always_comb begin
    req.a_mag = '0;
    req.b_mag = '0;
    req.neg   = 1'b0;
    req.sh16  = 1'b1;
    req.sat   = SAT63;
    unique case (op_q)
      OP_ANG: begin
        req.a_mag = mag48(total_q);
        req.b_mag = cfg_i.angle_scale;
        req.neg   = total_q[47];
        req.sat   = SAT48;
      end
      OP_SPD: begin
        req.a_mag = {32'b0, mag16(rpm_q)};
        req.b_mag = cfg_i.speed_scale;
        req.neg   = rpm_q[15];
        req.sh16  = 1'b0;
        req.sat   = SAT32;
      end
      OP_CUR: begin
        req.a_mag = {32'b0, mag16(raw_q)};
        req.b_mag = cfg_i.current_scale;
        req.neg   = raw_q[15];
        req.sh16  = 1'b0;
        req.sat   = SAT32;
      end
      OP_CS: begin
        req.a_mag = {16'b0, mag32(cur_q)};
        req.b_mag = mag32(spd_q);
        req.neg   = cur_q[31] ^ spd_q[31];
      end
      OP_SS: begin
        req.a_mag = {16'b0, mag32(spd_q)};
        req.b_mag = mag32(spd_q);
        req.neg   = 1'b0;
      end
      OP_CC: begin
        req.a_mag = {16'b0, mag32(cur_q)};
        req.b_mag = mag32(cur_q);
        req.neg   = 1'b0;
      end
      OP_KC: begin
        req.a_mag = mag48(term_q);
        req.b_mag = mag32(cfg_i.k_cross);
        req.neg   = term_q[47] ^ cfg_i.k_cross[31];
      end
      OP_KS: begin
        req.a_mag = mag48(term_q);
        req.b_mag = mag32(cfg_i.k_speed);
        req.neg   = term_q[47] ^ cfg_i.k_speed[31];
      end
      OP_KI: begin
        req.a_mag = mag48(term_q);
        req.b_mag = mag32(cfg_i.k_current);
        req.neg   = term_q[47] ^ cfg_i.k_current[31];
      end
      default: ;
    endcase
    req.start = (state_q == S_ISSUE);
  end

  assign mul_req_o = req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_ANG;
      last_pos_q   <= '0;
      turn_q       <= '0;
      frame_seen_q <= 1'b0;
      online_q     <= 1'b0;
      total_q      <= '0;
      ang_q        <= '0;
      spd_q        <= '0;
      cur_q        <= '0;
      tck_q        <= '0;
      pw_q         <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: if (accept) begin
          if (item_i.command == CMD_TICK) begin
            online_q     <= frame_seen_q;
            frame_seen_q <= 1'b0;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_UNWRAP;
          end
        end
        S_UNWRAP: begin
          turn_q       <= turn_d;
          last_pos_q   <= pos_q;
          frame_seen_q <= 1'b1;
          tck_q        <= tck_d;
          state_q      <= S_TOTAL;
        end
        S_TOTAL: begin
          total_q <= sat48(tot_full);
          op_q    <= OP_ANG;
          state_q <= S_ISSUE;
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: if (mul_done_i) begin
          unique case (op_q)
            OP_ANG:  ang_q <= mul_res_i[47:0];
            OP_SPD:  spd_q <= mul_res_i[31:0];
            OP_CUR:  cur_q <= mul_res_i[31:0];
            default: ;
          endcase
          if (op_q == OP_KI) begin
            state_q <= S_SAT;
          end else begin
            op_q    <= op_e'(op_q + 4'd1);
            state_q <= S_ISSUE;
          end
        end
        S_SAT: begin
          pw_q    <= sat48(pwacc_q);
          state_q <= S_DONE;
        end
        S_DONE: if (res_ready_i) begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q  <= item_i.rotor_position;
      rpm_q  <= item_i.speed_rpm;
      raw_q  <= item_i.current_raw;
      temp_q <= item_i.temperature_c;
    end
    if (state_q == S_TOTAL) begin
      pwacc_q <= {{32{cfg_i.offset[31]}}, cfg_i.offset};
    end
    if ((state_q == S_WAIT) && mul_done_i) begin
      unique case (op_q)
        OP_CS, OP_SS, OP_CC: term_q  <= mul_res_i[47:0];
        OP_KC, OP_KS, OP_KI: pwacc_q <= pwacc_q + mul_res_i;
        default: ;
      endcase
    end
  end

  assign res_o.turn_count_total = total_q;
  assign res_o.angle_rad        = ang_q;
  assign res_o.speed_rad_s      = spd_q;
  assign res_o.current_amp      = cur_q;
  assign res_o.temperature_ck   = tck_q;
  assign res_o.power_est        = pw_q;
  assign res_o.motor_online     = online_q;

  a_turn_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UNWRAP) |=> ((turn_q == $past(turn_q)) ||
                               (turn_q == $past(turn_q) + TURN_BITS'(1)) ||
                               (turn_q == $past(turn_q) - TURN_BITS'(1))))
    else $error("turn counter moved by more than one turn in a frame");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done_i |-> (state_q == S_WAIT))
    else $error("product arrived while the sequencer was not waiting for it");

  a_tick_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.command == CMD_TICK)) |=> (!frame_seen_q && (state_q == S_DONE)))
    else $error("heartbeat tick did not clear the frame-seen flag");

endmodule

`default_nettype wire

// ===== hdl/motor_feedback_decoder_unit.sv =====
// Top level of the motor feedback decoder: register port, sequencer, multiplier, output register.
// A feedback frame goes from its transfer to a valid result through unwrap, total and nine
// passes through the one shared 32x32 multiplier, then the power clamp.
// A heartbeat tick goes from the idle state straight to the done state, then to the output register.
// The input is ready only while the sequencer is idle, so it takes a new frame or tick only once
// the last result is in the output register. Reset clears turn count, last position, status and
// the sequencer's stored results to zero and loads the default scale factors.
`default_nettype none

module motor_feedback_decoder_unit
  import mfd_pkg::*;
#(
  parameter int unsigned COUNTS_PER_TURN = 8192,
  parameter int unsigned TURN_BITS       = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  mfd_in_if.sink                     feedback_i,
  mfd_out_if.source                  result_o
);

  cfg_t        cfg;
  in_item_t    item;
  mul_req_t    mul_req;
  logic        mul_done;
  logic [63:0] mul_res;
  logic        seq_ready;
  logic        res_valid;
  logic        res_ready;
  result_t     res;
  result_t     out_q;
  logic        out_valid_q;

  mfd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mfd_mul_unit u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign item.command        = cmd_e'(feedback_i.command);
  assign item.rotor_position = feedback_i.rotor_position;
  assign item.speed_rpm      = feedback_i.speed_rpm;
  assign item.current_raw    = feedback_i.current_raw;
  assign item.temperature_c  = feedback_i.temperature_c;

  mfd_seq #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN),
    .TURN_BITS       (TURN_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (feedback_i.valid),
    .in_ready_o  (seq_ready),
    .item_i      (item),
    .mul_req_o   (mul_req),
    .mul_done_i  (mul_done),
    .mul_res_i   (mul_res),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign feedback_i.ready = seq_ready;

  // The output register frees the sequencer as soon as a result is latched.
  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.turn_count_total = out_q.turn_count_total;
  assign result_o.angle_rad        = out_q.angle_rad;
  assign result_o.speed_rad_s      = out_q.speed_rad_s;
  assign result_o.current_amp      = out_q.current_amp;
  assign result_o.temperature_ck   = out_q.temperature_ck;
  assign result_o.power_est        = out_q.power_est;
  assign result_o.motor_online     = out_q.motor_online;

endmodule

`default_nettype wire
